/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define RPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define RPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/rpd_pkg.sv */
`default_nettype none

package rpd_pkg;

    localparam int ADDR_W            = 48;
    localparam int KIND_W            = 2;
    localparam int DEF_STORE_ENTRIES = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);

    localparam logic [KIND_W-1:0] KIND_MANAGEMENT = 2'd0;
    localparam logic [ADDR_W-1:0] ADDR_BROADCAST  = {ADDR_W{1'b1}};

    typedef struct packed {
        logic [KIND_W-1:0] frame_kind;
        logic [ADDR_W-1:0] addr_one;
        logic [ADDR_W-1:0] addr_two;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] new_addr_one;
        logic [ADDR_W-1:0] new_addr_two;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] second;
    } t_pair;

    // Queue side of the link between the front and back parts.
    typedef struct packed {
        logic  full;
        logic  empty;
        t_pair pair;
    } t_queue_stat;

endpackage

`default_nettype wire

/* rtl/rpd_queue.sv */
`default_nettype none

module rpd_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire rpd_pkg::t_pair      i_pair,
    input  wire logic                i_pop,
    output rpd_pkg::t_queue_stat     o_stat
);

    localparam int AW = rpd_pkg::QUEUE_AW;

    rpd_pkg::t_pair r_mem [rpd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;
    logic           wr_en;
    logic           rd_en;

    assign o_stat.full  = (r_cnt == (AW+1)'(rpd_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.pair  = r_mem[r_rd];
    assign wr_en        = i_push && !o_stat.full;
    assign rd_en        = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + AW'(1);
            end
            if (rd_en) begin
                r_rd <= r_rd + AW'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_pair;
        end
    end

endmodule

`default_nettype wire

/* rtl/rpd_front.sv */
`default_nettype none

module rpd_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire rpd_pkg::t_in_item    i_item,
    output logic                      o_q_push,
    output rpd_pkg::t_pair            o_q_pair,
    input  wire rpd_pkg::t_queue_stat i_q_stat
);

    logic           r_valid;
    rpd_pkg::t_pair r_pair;
    logic           n_valid;
    logic           keep;
    logic           accept;
    logic           drained;

    // Only management frames to a non-broadcast receiver go on to lookup.
    assign keep = (i_item.frame_kind == rpd_pkg::KIND_MANAGEMENT)
               && (i_item.addr_one != rpd_pkg::ADDR_BROADCAST);

    assign o_full   = r_valid && i_q_stat.full;
    assign accept   = i_push && !o_full;
    assign drained  = r_valid && !i_q_stat.full;
    assign o_q_push = r_valid;
    assign o_q_pair = r_pair;

    always_comb begin
        n_valid = r_valid;
        if (accept && keep) begin
            n_valid = 1'b1;
        end else if (drained) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_pair.first  <= i_item.addr_one;
            r_pair.second <= i_item.addr_two;
        end
    end

endmodule

`default_nettype wire

/* rtl/rpd_back.sv */
`default_nettype none

module rpd_back #(
    parameter int STORE_ENTRIES = rpd_pkg::DEF_STORE_ENTRIES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rpd_pkg::t_queue_stat i_q_stat,
    output logic                      o_q_pop,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output rpd_pkg::t_out_item        o_item
);

    localparam int            IW   = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(STORE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_WRITE
    } t_state;

    t_state                      r_state;
    rpd_pkg::t_pair              r_pair;
    logic [IW-1:0]               r_idx;
    logic [IW-1:0]               r_ptr;
    logic                        r_cmp;
    logic                        r_cmp_last;
    logic [STORE_ENTRIES-1:0]    r_valid;
    logic                        r_rd_valid;
    logic [rpd_pkg::ADDR_W-1:0]  r_rd_first;
    logic [rpd_pkg::ADDR_W-1:0]  r_rd_second;
    logic                        r_out_valid;
    rpd_pkg::t_out_item          r_out;

    logic [rpd_pkg::ADDR_W-1:0]  r_mem_first  [STORE_ENTRIES];
    logic [rpd_pkg::ADDR_W-1:0]  r_mem_second [STORE_ENTRIES];

    logic [rpd_pkg::ADDR_W-1:0]  rd_first_eff;
    logic [rpd_pkg::ADDR_W-1:0]  rd_second_eff;
    logic                        hit;
    logic                        out_free;
    logic                        wr_en;

    // An entry never written since reset reads as an all-zero pair.
    assign rd_first_eff  = r_rd_valid ? r_rd_first  : '0;
    assign rd_second_eff = r_rd_valid ? r_rd_second : '0;
    assign hit = r_cmp && (rd_first_eff == r_pair.first)
                       && (rd_second_eff == r_pair.second);

    assign out_free = !r_out_valid || i_pop;
    assign wr_en    = (r_state == S_WRITE) && out_free;
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_empty  = !r_out_valid;
    assign o_item   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_ptr       <= '0;
            r_cmp       <= 1'b0;
            r_cmp_last  <= 1'b0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_pop && !wr_en) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_pair     <= i_q_stat.pair;
                        r_idx      <= '0;
                        r_cmp      <= 1'b0;
                        r_cmp_last <= 1'b0;
                        r_state    <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // Read one entry per cycle; compare it the cycle after.
                    r_rd_valid <= r_valid[r_idx];
                    r_cmp      <= 1'b1;
                    r_cmp_last <= (r_idx == LAST);
                    if (r_idx != LAST) begin
                        r_idx <= r_idx + IW'(1);
                    end
                    if (hit) begin
                        r_state <= S_IDLE;
                    end else if (r_cmp && r_cmp_last) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (out_free) begin
                        r_valid[r_ptr]     <= 1'b1;
                        r_ptr              <= (r_ptr == LAST) ? '0 : r_ptr + IW'(1);
                        r_out_valid        <= 1'b1;
                        r_out.new_addr_one <= r_pair.first;
                        r_out.new_addr_two <= r_pair.second;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_first[r_ptr]  <= r_pair.first;
            r_mem_second[r_ptr] <= r_pair.second;
        end
        r_rd_first  <= r_mem_first[r_idx];
        r_rd_second <= r_mem_second[r_idx];
    end

endmodule

`default_nettype wire

/* rtl/recent_pair_dedup_filter.sv */
// Recent address pair filter for captured management frame headers.
// Input channel: drive i_item and raise push; the header is taken on a
// clock edge with push high and full low. Non-management frames, and
// frames to the broadcast receiver, are taken and dropped at once.
// Result channel: while empty is low, o_item holds the oldest new pair;
// it is taken on a clock edge with pop high.
// Each kept header passes a registered classify stage and a four-entry
// queue, then a lookup engine compares the store one entry per cycle
// through its registered read port, ending early on a hit. A miss is
// put on the result port and written over the store entry at a
// round-robin pointer.
// Reset (synchronous, active low) empties the queue and output, sets the
// pointer to entry zero and clears all entry valid bits, so every entry
// reads as an all-zero pair; no clearing sweep follows.
// When pop stays low, the engine holds its finished result in S_WRITE, the
// queue fills, and full rises once the classify stage also holds a header.
`default_nettype none

module recent_pair_dedup_filter #(
    parameter int STORE_ENTRIES = rpd_pkg::DEF_STORE_ENTRIES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire rpd_pkg::t_in_item  i_item,
    output logic                    empty,
    input  wire logic               pop,
    output rpd_pkg::t_out_item      o_item
);

    logic                 q_push;
    rpd_pkg::t_pair       q_pair;
    logic                 q_pop;
    rpd_pkg::t_queue_stat q_stat;

    rpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .o_q_push (q_push),
        .o_q_pair (q_pair),
        .i_q_stat (q_stat)
    );

    rpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pair  (q_pair),
        .i_pop   (q_pop),
        .o_stat  (q_stat)
    );

    rpd_back #(
        .STORE_ENTRIES (STORE_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .o_q_pop  (q_pop),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_item   (o_item)
    );

endmodule

`default_nettype wire

/* rtl/rpd_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module rpd_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               push,
    input wire logic               full,
    input wire rpd_pkg::t_in_item  i_item,
    input wire logic               empty,
    input wire logic               pop,
    input wire rpd_pkg::t_out_item o_item
);

    `RPD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> empty, "output not empty after reset")
    `RPD_ASSERT_ALWAYS(a_reset_not_full, i_clk, !i_rst_n |=> !full, "input full after reset")
    `RPD_ASSERT(a_no_broadcast, i_clk, i_rst_n, !empty |-> o_item.new_addr_one != rpd_pkg::ADDR_BROADCAST, "broadcast pair emitted")
    `RPD_ASSERT(a_hold_result, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_item), "pending result changed")

endmodule

bind recent_pair_dedup_filter rpd_checker u_rpd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .i_item  (i_item),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int STORE_ENTRIES   = rpd_pkg::DEF_STORE_ENTRIES;
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 2 * STORE_ENTRIES + 10;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASE_FRAMES    = 240;
    localparam int POOL_SIZE       = 24;

    localparam logic [rpd_pkg::KIND_W-1:0] KIND_CONTROL = 2'd1;
    localparam logic [rpd_pkg::KIND_W-1:0] KIND_DATA    = 2'd2;
    localparam logic [rpd_pkg::KIND_W-1:0] KIND_MISC    = 2'd3;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push    = 1'b0;
    logic               pop     = 1'b0;
    rpd_pkg::t_in_item  i_item  = '0;
    logic               full;
    logic               empty;
    rpd_pkg::t_out_item o_item;

    // Model of the recent-pair store
    logic [rpd_pkg::ADDR_W-1:0] seen_first  [STORE_ENTRIES];
    logic [rpd_pkg::ADDR_W-1:0] seen_second [STORE_ENTRIES];
    int                         next_slot;

    rpd_pkg::t_in_item  frame_queue[$];
    rpd_pkg::t_out_item pending_pairs[$];

    logic [rpd_pkg::ADDR_W-1:0] pool_one [POOL_SIZE];
    logic [rpd_pkg::ADDR_W-1:0] pool_two [POOL_SIZE];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_off_req       = 1'b0;
    int hold_off_left      = 0;
    int error_count        = 0;
    int cycle_count        = 0;

    rpd_pkg::t_in_item  accepted_frame;
    rpd_pkg::t_out_item fresh_pair;
    rpd_pkg::t_out_item expected_pair;

    recent_pair_dedup_filter #(
        .STORE_ENTRIES(STORE_ENTRIES)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_item (i_item),
        .empty  (empty),
        .pop    (pop),
        .o_item (o_item)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic void clear_store();
        for (int i = 0; i < STORE_ENTRIES; i++) begin
            seen_first[i]  = '0;
            seen_second[i] = '0;
        end
        next_slot = 0;
    endfunction

    // Return 1 and the pair when a management frame to a non-broadcast receiver carries a pair not yet in the store
    function automatic bit predict_new_pair(input rpd_pkg::t_in_item frame,
                                            output rpd_pkg::t_out_item pair);
        pair = '0;
        if (frame.frame_kind != rpd_pkg::KIND_MANAGEMENT) return 1'b0;
        if (frame.addr_one == rpd_pkg::ADDR_BROADCAST) return 1'b0;
        for (int i = 0; i < STORE_ENTRIES; i++) begin
            if (seen_first[i] == frame.addr_one && seen_second[i] == frame.addr_two)
                return 1'b0;
        end
        seen_first[next_slot]  = frame.addr_one;
        seen_second[next_slot] = frame.addr_two;
        next_slot = (next_slot == STORE_ENTRIES - 1) ? 0 : next_slot + 1;
        pair.new_addr_one = frame.addr_one;
        pair.new_addr_two = frame.addr_two;
        return 1'b1;
    endfunction

    function automatic logic [rpd_pkg::ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[rpd_pkg::ADDR_W-1:0];
    endfunction

    function automatic void add_frame(input logic [rpd_pkg::KIND_W-1:0] kind,
                                      input logic [rpd_pkg::ADDR_W-1:0] a,
                                      input logic [rpd_pkg::ADDR_W-1:0] b);
        rpd_pkg::t_in_item f;
        f.frame_kind = kind;
        f.addr_one   = a;
        f.addr_two   = b;
        frame_queue.push_back(f);
    endfunction

    // Queue random headers until the given number of non-ignored frames is reached
    function automatic void add_random_frames(input int quota);
        int                         counted;
        int                         pick;
        int                         idx;
        logic [rpd_pkg::ADDR_W-1:0] a;
        logic [rpd_pkg::ADDR_W-1:0] b;
        counted = 0;
        while (counted < quota) begin
            pick = $urandom_range(99);
            idx  = $urandom_range(POOL_SIZE - 1);
            if ($urandom_range(19) == 0) begin
                pool_one[idx] = rand_addr();
                pool_two[idx] = rand_addr();
            end
            a = pool_one[idx];
            b = pool_two[idx];
            if (pick < 60) begin
                add_frame(rpd_pkg::KIND_MANAGEMENT, a, b);
                counted++;
            end else if (pick < 72) begin
                add_frame(rpd_pkg::KIND_MANAGEMENT, rand_addr(), rand_addr());
                counted++;
            end else if (pick < 79) begin
                // flip one bit of a known pair: must not match it
                if ($urandom_range(1) == 0)
                    a[$urandom_range(rpd_pkg::ADDR_W - 1)] ^= 1'b1;
                else
                    b[$urandom_range(rpd_pkg::ADDR_W - 1)] ^= 1'b1;
                add_frame(rpd_pkg::KIND_MANAGEMENT, a, b);
                counted++;
            end else if (pick < 83) begin
                add_frame(rpd_pkg::KIND_MANAGEMENT, ($urandom_range(1) == 0) ? '0 : a,
                          ($urandom_range(1) == 0) ? '0 : b);
                counted++;
            end else if (pick < 93) begin
                add_frame(rpd_pkg::KIND_W'($urandom_range(3, 1)), a, b);
            end else begin
                add_frame(rpd_pkg::KIND_W'($urandom_range(3)), rpd_pkg::ADDR_BROADCAST,
                          ($urandom_range(1) == 0) ? b : rand_addr());
            end
        end
    endfunction

    // Wait until every queued frame is taken and every expected pair has come out
    task automatic drain();
        while (frame_queue.size() != 0 || push)
            @(negedge i_clk);
        while (pending_pairs.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                accepted_frame = frame_queue.pop_front();
                if (predict_new_pair(accepted_frame, fresh_pair))
                    pending_pairs.push_back(fresh_pair);
            end
            if (push && full) begin
                // hold the offered transaction
            end else if (frame_queue.size() != 0 &&
                         $urandom_range(99) >= sender_idle_pct) begin
                push   <= 1'b1;
                i_item <= frame_queue[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_off_left != 0)
            hold_off_left <= hold_off_left - 1;
        else if (hold_off_req)
            hold_off_left <= HOLD_OFF_CYCLES;
    end

    // Monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_pairs.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got %h / %h",
                             $time, o_item.new_addr_one, o_item.new_addr_two);
                    error_count++;
                end else begin
                    expected_pair = pending_pairs.pop_front();
                    if (o_item.new_addr_one !== expected_pair.new_addr_one) begin
                        $display("%0t: new_addr_one mismatch: expected %h, got %h",
                                 $time, expected_pair.new_addr_one, o_item.new_addr_one);
                        error_count++;
                    end
                    if (o_item.new_addr_two !== expected_pair.new_addr_two) begin
                        $display("%0t: new_addr_two mismatch: expected %h, got %h",
                                 $time, expected_pair.new_addr_two, o_item.new_addr_two);
                        error_count++;
                    end
                end
            end
            pop <= (hold_off_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        clear_store();
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_one[i] = rand_addr();
            pool_two[i] = rand_addr();
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero pair counts as seen until the pointer wraps
        add_frame(rpd_pkg::KIND_MANAGEMENT, '0, '0);
        add_frame(rpd_pkg::KIND_MANAGEMENT, '0, 48'd1);
        add_frame(rpd_pkg::KIND_MANAGEMENT, '0, 48'd1);
        add_frame(KIND_CONTROL, rand_addr(), rand_addr());
        add_frame(KIND_DATA, rand_addr(), rand_addr());
        add_frame(KIND_MISC, rand_addr(), rand_addr());
        add_frame(rpd_pkg::KIND_MANAGEMENT, rpd_pkg::ADDR_BROADCAST, rand_addr());
        add_frame(rpd_pkg::KIND_MANAGEMENT, rpd_pkg::ADDR_BROADCAST, '0);
        add_frame(rpd_pkg::KIND_MANAGEMENT, rpd_pkg::ADDR_BROADCAST - 1,
                  rpd_pkg::ADDR_BROADCAST);
        add_frame(rpd_pkg::KIND_MANAGEMENT, 48'd1, '0);
        for (int i = 0; i < 13; i++)
            add_frame(rpd_pkg::KIND_MANAGEMENT, rpd_pkg::ADDR_W'(i + 2),
                      ~rpd_pkg::ADDR_W'(i));
        add_frame(rpd_pkg::KIND_MANAGEMENT, '0, '0);
        add_frame(rpd_pkg::KIND_MANAGEMENT, '0, 48'd1);
        drain();

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        add_random_frames(PHASE_FRAMES);
        drain();

        sender_idle_pct = 62;
        add_random_frames(PHASE_FRAMES);
        drain();

        sender_idle_pct    = 0;
        receiver_stall_pct = 62;
        add_random_frames(PHASE_FRAMES);
        drain();

        sender_idle_pct    = 32;
        receiver_stall_pct = 32;
        add_random_frames(PHASE_FRAMES);
        drain();

        // Hold the receiver off while frames keep coming, so full must rise
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_req       = 1'b1;
        while (hold_off_left == 0)
            @(negedge i_clk);
        hold_off_req = 1'b0;
        add_random_frames(PHASE_FRAMES);
        drain();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
